/* rtl/core/mtlsd_pkg.sv */
// Shared types, constants and the microcode table for the torque limiter core.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package mtlsd_pkg;

  // Field widths fixed by the item and register formats
  localparam int EffortW  = 24;
  localparam int VelW     = 24;
  localparam int StepW    = 16;
  localparam int DriveW   = 21;
  localparam int LimitW   = 20;
  localparam int SlopeW   = 24;
  localparam int TimeW    = 24;
  localparam int IdW      = 8;
  localparam int EnW      = 3;
  localparam int CfgDataW = 24;
  localparam int CfgIdxW  = 3;
  localparam int MulW     = 24;
  localparam int PcW      = 4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_BASE_CEIL    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FEATURE_EN   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DERATE_SLOPE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CURRENT_CAP  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_STALL_VEL    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STALL_TIME   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FAULT_ID     = 3'd6;

  // Bits of feature_enables
  localparam int EN_DERATE = 0;
  localparam int EN_CAP    = 1;
  localparam int EN_STALL  = 2;

  // Register reset values
  localparam logic [LimitW-1:0] RST_BASE_CEIL    = 20'd184320;
  localparam logic [EnW-1:0]    RST_FEATURE_EN   = 3'd0;
  localparam logic [SlopeW-1:0] RST_DERATE_SLOPE = 24'd24055;
  localparam logic [LimitW-1:0] RST_CURRENT_CAP  = 20'd8192;
  localparam logic [LimitW-1:0] RST_STALL_VEL    = 20'd41;
  localparam logic [TimeW-1:0]  RST_STALL_TIME   = 24'd500000;
  localparam logic [IdW-1:0]    RST_FAULT_ID     = 8'd0;

  typedef struct packed {
    logic signed [EffortW-1:0] raw_effort;
    logic signed [VelW-1:0]    measured_velocity;
    logic [StepW-1:0]          step_time;
  } in_item_t;

  typedef struct packed {
    logic signed [DriveW-1:0] drive_effort;
    logic [LimitW-1:0]        effort_limit;
    logic                     stall_fault;
    logic [IdW-1:0]           fault_code;
  } out_item_t;

  typedef struct packed {
    logic [LimitW-1:0] base_ceiling;
    logic [EnW-1:0]    feature_enables;
    logic [SlopeW-1:0] derate_slope;
    logic [LimitW-1:0] current_effort_cap;
    logic [LimitW-1:0] still_speed_max;
    logic [TimeW-1:0]  stall_time;
    logic [IdW-1:0]    fault_id;
  } cfg_t;

  // Datapath operations, one per microcode step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_BASE,
    OP_MUL_SLOPE,
    OP_FACTOR,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ACC,
    OP_DERATE,
    OP_CAP,
    OP_CLAMP,
    OP_NEAR,
    OP_STALL,
    OP_EMIT
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_WAIT_IN,
    COND_NO_DERATE,
    COND_NO_STALL,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t            op;
    cond_t          cond;
    logic [PcW-1:0] target;
    logic           last;
  } uword_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic derate_off;
    logic stall_skip;
  } dp_stat_t;

  // Program addresses
  localparam logic [PcW-1:0] PC_LOAD      = 4'd0;
  localparam logic [PcW-1:0] PC_BASE      = 4'd1;
  localparam logic [PcW-1:0] PC_MUL_SLOPE = 4'd2;
  localparam logic [PcW-1:0] PC_FACTOR    = 4'd3;
  localparam logic [PcW-1:0] PC_MUL_LO    = 4'd4;
  localparam logic [PcW-1:0] PC_MUL_HI    = 4'd5;
  localparam logic [PcW-1:0] PC_ACC       = 4'd6;
  localparam logic [PcW-1:0] PC_DERATE    = 4'd7;
  localparam logic [PcW-1:0] PC_CAP       = 4'd8;
  localparam logic [PcW-1:0] PC_CLAMP     = 4'd9;
  localparam logic [PcW-1:0] PC_NEAR      = 4'd10;
  localparam logic [PcW-1:0] PC_STALL     = 4'd11;
  localparam logic [PcW-1:0] PC_EMIT      = 4'd12;

  function automatic uword_t mk_uword(input op_t op, input cond_t cond,
                                      input logic [PcW-1:0] target, input logic last);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // Control store: jump to target when the condition holds, else advance
  // (or wrap to the load step after the last word)
  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      PC_LOAD:      w = mk_uword(OP_LOAD,      COND_WAIT_IN,   PC_LOAD, 1'b0);
      PC_BASE:      w = mk_uword(OP_BASE,      COND_NO_DERATE, PC_CAP,  1'b0);
      PC_MUL_SLOPE: w = mk_uword(OP_MUL_SLOPE, COND_NEVER,     PC_LOAD, 1'b0);
      PC_FACTOR:    w = mk_uword(OP_FACTOR,    COND_NEVER,     PC_LOAD, 1'b0);
      PC_MUL_LO:    w = mk_uword(OP_MUL_LO,    COND_NEVER,     PC_LOAD, 1'b0);
      PC_MUL_HI:    w = mk_uword(OP_MUL_HI,    COND_NEVER,     PC_LOAD, 1'b0);
      PC_ACC:       w = mk_uword(OP_ACC,       COND_NEVER,     PC_LOAD, 1'b0);
      PC_DERATE:    w = mk_uword(OP_DERATE,    COND_NEVER,     PC_LOAD, 1'b0);
      PC_CAP:       w = mk_uword(OP_CAP,       COND_NEVER,     PC_LOAD, 1'b0);
      PC_CLAMP:     w = mk_uword(OP_CLAMP,     COND_NO_STALL,  PC_EMIT, 1'b0);
      PC_NEAR:      w = mk_uword(OP_NEAR,      COND_NEVER,     PC_LOAD, 1'b0);
      PC_STALL:     w = mk_uword(OP_STALL,     COND_NEVER,     PC_LOAD, 1'b0);
      PC_EMIT:      w = mk_uword(OP_EMIT,      COND_OUT_BUSY,  PC_EMIT, 1'b1);
      default:      w = mk_uword(OP_NOP,       COND_NEVER,     PC_LOAD, 1'b1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mtlsd_sequencer.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on mtlsd_pkg (uword_t, dp_stat_t, ucode).
`default_nettype none

module mtlsd_sequencer
  import mtlsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dp_stat_t stat,
  output uword_t   uw
);

  logic [PcW-1:0] pc_r, pc_nxt;
  logic           take_jump;

  // Fetch the current control word
  assign uw = ucode(pc_r);

  // Evaluate the jump condition
  always_comb begin
    case (uw.cond)
      COND_NEVER:     take_jump = 1'b0;
      COND_WAIT_IN:   take_jump = !stat.in_valid;
      COND_NO_DERATE: take_jump = stat.derate_off;
      COND_NO_STALL:  take_jump = stat.stall_skip;
      COND_OUT_BUSY:  take_jump = stat.out_busy;
      default:        take_jump = 1'b0;
    endcase
  end

  // Jump, wrap or advance
  always_comb begin
    if (take_jump) begin
      pc_nxt = uw.target;
    end else if (uw.last) begin
      pc_nxt = PC_LOAD;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mtlsd_datapath.sv */
// Datapath driven by the microcode: shared 24x24 multiplier, limit and clamp
// logic, stall timer state and the output register. Depends on mtlsd_pkg.
`default_nettype none

module mtlsd_datapath
  import mtlsd_pkg::*;
#(
  parameter int FRAC_BITS        = 12,
  parameter int STALL_TIMER_BITS = 25
) (
  input  logic      clk,
  input  logic      rst_n,
  input  uword_t    uw,
  input  cfg_t      cfg,
  input  logic      in_valid,
  input  in_item_t  in_item,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_item,
  output dp_stat_t  stat
);

  localparam int ProdW   = 2 * MulW;
  localparam int OneSh   = FRAC_BITS + SlopeW;
  localparam int FactW   = OneSh + 1;
  localparam int AccW    = LimitW + FactW;
  localparam int HiW     = FactW - MulW;
  localparam int TimerW  = STALL_TIMER_BITS;
  localparam int CmpW    = (TimerW > TimeW) ? TimerW : TimeW;
  localparam logic [ProdW-1:0] One = ProdW'(1) << OneSh;

  // Item registers
  logic signed [EffortW-1:0] effort_r;
  logic [VelW-1:0]           speed_r;
  logic [StepW-1:0]          dt_r;
  // Arithmetic registers
  logic [ProdW-1:0]          prod_r;
  logic [FactW-1:0]          factor_r;
  logic [AccW-1:0]           acc_r;
  logic [LimitW-1:0]         limit_r;
  logic signed [DriveW-1:0]  drive_r;
  logic [DriveW-1:0]         mag_r;
  logic                      at_max_r, still_r;
  // Control registers
  logic                      fault_r;
  logic [TimerW-1:0]         elapsed_r;
  logic                      reported_r;
  logic                      out_valid_r;
  out_item_t                 out_item_r;

  logic [MulW-1:0]           mul_a, mul_b;
  logic [ProdW-1:0]          mul_p;
  logic [VelW-1:0]           speed_in;
  logic [FactW-1:0]          factor_nxt;
  logic [AccW-1:0]           acc_sum;
  logic [LimitW-1:0]         derated, capped;
  logic signed [EffortW:0]   eff_x, lim_x, clamp_x;
  logic [DriveW-1:0]         mag_nxt;
  logic                      at_max_nxt, still_nxt;
  logic [TimerW:0]           timer_sum;
  logic [TimerW-1:0]         elapsed_sat;
  logic                      time_reached;
  logic                      load_go, slot_free, emit_go;

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uw.op)
      OP_MUL_SLOPE: begin
        mul_a = speed_r;
        mul_b = cfg.derate_slope;
      end
      OP_MUL_LO: begin
        mul_a = MulW'(cfg.base_ceiling);
        mul_b = factor_r[MulW-1:0];
      end
      OP_MUL_HI: begin
        mul_a = MulW'(cfg.base_ceiling);
        mul_b = MulW'(factor_r[FactW-1 -: HiW]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Speed magnitude of the incoming beat
  assign speed_in = in_item.measured_velocity[VelW-1] ?
                    VelW'(-in_item.measured_velocity) : VelW'(in_item.measured_velocity);

  // Derating factor, floored at zero
  assign factor_nxt = (prod_r >= One) ? '0 : FactW'(One - prod_r);
  assign acc_sum    = acc_r + (AccW'(prod_r) << MulW);
  assign derated    = acc_r[OneSh +: LimitW];

  // Current ceiling
  assign capped = (cfg.feature_enables[EN_CAP] && (cfg.current_effort_cap < limit_r)) ?
                  cfg.current_effort_cap : limit_r;

  // Clamp to plus or minus the ceiling
  always_comb begin
    eff_x = (EffortW+1)'(effort_r);
    lim_x = $signed({{(EffortW+1-LimitW){1'b0}}, limit_r});
    if (eff_x > lim_x) begin
      clamp_x = lim_x;
    end else if (eff_x < -lim_x) begin
      clamp_x = -lim_x;
    end else begin
      clamp_x = eff_x;
    end
    mag_nxt = clamp_x[EffortW] ? DriveW'(-clamp_x) : clamp_x[DriveW-1:0];
  end

  // Near-maximum (50 |drive| >= 49 limit) and no-motion tests
  assign at_max_nxt = (27'(mag_r) * 27'd50) >= (27'(limit_r) * 27'd49);
  assign still_nxt  = speed_r < VelW'(cfg.still_speed_max);

  // Saturating stall timer
  assign timer_sum    = {1'b0, elapsed_r} + (TimerW+1)'(dt_r);
  assign elapsed_sat  = timer_sum[TimerW] ? '1 : timer_sum[TimerW-1:0];
  assign time_reached = CmpW'(elapsed_sat) >= CmpW'(cfg.stall_time);

  assign load_go   = (uw.op == OP_LOAD) && in_valid;
  assign slot_free = !out_valid_r || out_ready;
  assign emit_go   = (uw.op == OP_EMIT) && slot_free;

  // Status for the sequencer
  assign stat.in_valid   = in_valid;
  assign stat.out_busy   = !slot_free;
  assign stat.derate_off = !cfg.feature_enables[EN_DERATE];
  assign stat.stall_skip = !cfg.feature_enables[EN_STALL] || (dt_r == '0);

  // Advance the arithmetic registers per control word
  always_ff @(posedge clk) begin
    if (load_go) begin
      effort_r <= in_item.raw_effort;
      speed_r  <= speed_in;
      dt_r     <= in_item.step_time;
    end
    case (uw.op)
      OP_BASE:      limit_r  <= cfg.base_ceiling;
      OP_MUL_SLOPE: prod_r   <= mul_p;
      OP_FACTOR:    factor_r <= factor_nxt;
      OP_MUL_LO:    prod_r   <= mul_p;
      OP_MUL_HI: begin
        prod_r <= mul_p;
        acc_r  <= AccW'(prod_r);
      end
      OP_ACC:       acc_r    <= acc_sum;
      OP_DERATE:    limit_r  <= derated;
      OP_CAP:       limit_r  <= capped;
      OP_CLAMP: begin
        drive_r <= clamp_x[DriveW-1:0];
        mag_r   <= mag_nxt;
      end
      OP_NEAR: begin
        at_max_r <= at_max_nxt;
        still_r  <= still_nxt;
      end
      default: begin
      end
    endcase
    if (emit_go) begin
      out_item_r.drive_effort <= drive_r;
      out_item_r.effort_limit <= limit_r;
      out_item_r.stall_fault  <= fault_r;
      out_item_r.fault_code   <= fault_r ? cfg.fault_id : '0;
    end
  end

  // Stall state, fault flag and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r     <= 1'b0;
      elapsed_r   <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_go) begin
        fault_r <= 1'b0;
      end
      if (uw.op == OP_STALL) begin
        if (at_max_r && still_r) begin
          elapsed_r <= elapsed_sat;
          if (time_reached && !reported_r) begin
            fault_r    <= 1'b1;
            reported_r <= 1'b1;
          end
        end else begin
          elapsed_r  <= '0;
          reported_r <= 1'b0;
        end
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

/* rtl/core/motor_torque_limiter_stall_detect_core.sv */
// Top level of the motor torque limiter with stall detection: configuration
// registers, microcode sequencer and datapath. Depends on mtlsd_pkg,
// mtlsd_sequencer and mtlsd_datapath.
//
//   Channel  Direction  Handshake                  Payload
//   in_      input      in_valid / in_ready        in_item  (in_item_t)
//   out_     output     out_valid / out_ready      out_item (out_item_t)
//   cfg_     input      cfg_we, no wait            cfg_index, cfg_wdata
//
// A beat runs load, base, derating, cap, clamp, near, stall and emit steps;
// derating is skipped with back-EMF derating off, near and stall when stall
// detection is skipped. The next beat is accepted once emit returns to the
// load step. Derating runs three products through one shared 24x24
// multiplier. Reset returns the step counter to the load step and clears the
// stall timer and output valid. A stalled output holds the sequencer at its
// last step; the finished result waits until the output register is free.
`default_nettype none

module motor_torque_limiter_stall_detect_core
  import mtlsd_pkg::*;
#(
  parameter int FRAC_BITS        = 12,
  parameter int STALL_TIMER_BITS = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t     cfg_r;
  uword_t   uw;
  dp_stat_t stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_ceiling       <= RST_BASE_CEIL;
      cfg_r.feature_enables    <= RST_FEATURE_EN;
      cfg_r.derate_slope       <= RST_DERATE_SLOPE;
      cfg_r.current_effort_cap <= RST_CURRENT_CAP;
      cfg_r.still_speed_max    <= RST_STALL_VEL;
      cfg_r.stall_time         <= RST_STALL_TIME;
      cfg_r.fault_id           <= RST_FAULT_ID;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_CEIL:    cfg_r.base_ceiling       <= cfg_wdata[LimitW-1:0];
        REG_FEATURE_EN:   cfg_r.feature_enables    <= cfg_wdata[EnW-1:0];
        REG_DERATE_SLOPE: cfg_r.derate_slope       <= cfg_wdata[SlopeW-1:0];
        REG_CURRENT_CAP:  cfg_r.current_effort_cap <= cfg_wdata[LimitW-1:0];
        REG_STALL_VEL:    cfg_r.still_speed_max    <= cfg_wdata[LimitW-1:0];
        REG_STALL_TIME:   cfg_r.stall_time         <= cfg_wdata[TimeW-1:0];
        REG_FAULT_ID:     cfg_r.fault_id           <= cfg_wdata[IdW-1:0];
        default: begin
        end
      endcase
    end
  end

  mtlsd_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uw    (uw)
  );

  mtlsd_datapath #(
    .FRAC_BITS        (FRAC_BITS),
    .STALL_TIMER_BITS (STALL_TIMER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .uw        (uw),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .stat      (stat)
  );

  // Take a beat only at the load step
  assign in_ready = (uw.op == OP_LOAD);

  // One beat in flight: after an accept the sequencer leaves the load step
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // The drive never exceeds the ceiling reported with it
  a_drive_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.drive_effort <= $signed({1'b0, out_item.effort_limit})) &&
                  (out_item.drive_effort >= -$signed({1'b0, out_item.effort_limit})))
    else $error("drive effort outside effort limit");

  // A fault carries the configured identifier, no fault carries zero
  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.stall_fault ? (out_item.fault_code == cfg_r.fault_id)
                                        : (out_item.fault_code == '0)))
    else $error("fault code does not match fault flag");

endmodule

`default_nettype wire
